/* src/sawq_pkg.sv */
`default_nettype none

package sawq_pkg;

  // Field widths that the interface fixes.
  localparam int TAG_W     = 16;
  localparam int OSEQ_W    = 16;
  localparam int TIMER_W   = 16;
  localparam int QCOUNT_W  = 5;

  // Defaults for the top-level parameters.
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int SEQ_WIDTH_DEF   = 16;

  // Timeout register value after reset.
  localparam logic [TIMER_W-1:0] TIMEOUT_RESET = TIMER_W'(1000);

  typedef enum logic [1:0] {
    FUNC_ARRIVAL = 2'd0,
    FUNC_ACK     = 2'd1,
    FUNC_DONE    = 2'd2,
    FUNC_TICK    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_SENDING = 2'd1,
    MODE_WAIT    = 2'd2
  } mode_t;

  typedef struct packed {
    func_t              func;
    logic [TAG_W-1:0]   packet_tag;
    logic               link_busy;
  } in_t;

  typedef struct packed {
    logic                send_now;
    logic [TAG_W-1:0]    send_tag;
    logic [OSEQ_W-1:0]   send_seq;
    logic                is_resend;
    logic [1:0]          sender_mode;
    logic [QCOUNT_W-1:0] queued_count;
    logic                dropped;
  } out_t;

endpackage

`default_nettype wire

/* src/stop_and_wait_sender_queue_unit.sv */
// Channel  | Direction | Ports                          | Transaction
// ---------+-----------+--------------------------------+-------------------------------------
// in       | input     | in_valid, in_stall, in_data    | one event (arrival, ACK, done, tick)
// out      | output    | out_valid, out_stall, out_data | one result per event
// cfg      | input     | cfg_we, cfg_wdata              | write of the timeout register
//
// One event is accepted per clock cycle while in_stall is low; its result is registered in
// the output (or skid) register. The FIFO read port pre-reads the head entry each cycle.
// Reset (rst_n, synchronous, active low) empties the queue and returns the sender to
// idle; no clearing pass is needed, the queue storage is simply never read unwritten.
// A stalled output holds its result; one more result fits in a skid register, and
// in_stall rises only while that skid register is occupied.

`default_nettype none

module stop_and_wait_sender_queue_unit
  import sawq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int SEQ_WIDTH   = SEQ_WIDTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire in_t                 in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output out_t                     out_data,
  input  wire logic                cfg_we,
  input  wire logic [TIMER_W-1:0]  cfg_wdata
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = TAG_W + SEQ_WIDTH;

  typedef logic [PW-1:0]        ptr_t;
  typedef logic [CW-1:0]        cnt_t;
  typedef logic [SEQ_WIDTH-1:0] seq_t;
  typedef logic [EW-1:0]        entry_t;

  function automatic ptr_t ptr_inc(input ptr_t p);
    ptr_t r;
    if (p == PW'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  // Architectural state.
  mode_t              mode_r,    mode_nxt;
  seq_t               next_seq_r, next_seq_nxt;
  ptr_t               head_r,    head_nxt;
  ptr_t               tail_r,    tail_nxt;
  cnt_t               count_r,   count_nxt;
  logic [TAG_W-1:0]   last_tag_r, last_tag_nxt;
  seq_t               last_seq_r, last_seq_nxt;
  logic [TIMER_W-1:0] timer_r,   timer_nxt;
  logic               armed_r,   armed_nxt;
  logic [TIMER_W-1:0] timeout_r;

  // Queue storage: one write port at the tail, one registered read port that always
  // holds the entry at the current head.
  entry_t mem [QUEUE_DEPTH];
  entry_t rd_data_r;
  ptr_t   rd_addr;
  logic   wr_en;
  entry_t wr_data;

  // Output register and skid register.
  out_t   res;
  out_t   skid_r;
  logic   skid_valid_r;
  logic   accept;
  logic   out_hold;

  // Per-event working signals.
  logic              push, pop, send, resend, drop;
  logic [TAG_W-1:0]  s_tag;
  seq_t              s_seq;
  logic [TIMER_W-1:0] timer_dec;

  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !skid_valid_r;
  assign out_hold = out_valid && out_stall;

  // Event processing. Everything is computed as if the event were accepted; the state
  // registers load only on an accepted transaction.
  always_comb begin
    mode_nxt     = mode_r;
    next_seq_nxt = next_seq_r;
    last_tag_nxt = last_tag_r;
    last_seq_nxt = last_seq_r;
    timer_nxt    = timer_r;
    armed_nxt    = armed_r;
    push         = 1'b0;
    pop          = 1'b0;
    send         = 1'b0;
    resend       = 1'b0;
    drop         = 1'b0;
    s_tag        = '0;
    s_seq        = '0;
    wr_data      = {in_data.packet_tag, next_seq_r};
    timer_dec    = timer_r - 1'b1;

    unique case (in_data.func)
      FUNC_ARRIVAL: begin
        if (mode_r == MODE_IDLE && !in_data.link_busy) begin
          // Send now; if packets are already queued the oldest one goes first and
          // the newcomer joins the back of the queue.
          next_seq_nxt = next_seq_r + 1'b1;
          send         = 1'b1;
          if (count_r == '0) begin
            s_tag = in_data.packet_tag;
            s_seq = next_seq_r;
          end else begin
            pop   = 1'b1;
            push  = 1'b1;
            s_tag = rd_data_r[EW-1 -: TAG_W];
            s_seq = rd_data_r[SEQ_WIDTH-1:0];
          end
        end else if (count_r == CW'(QUEUE_DEPTH)) begin
          // Full queue: the packet is lost and takes no sequence number.
          drop = 1'b1;
        end else begin
          push         = 1'b1;
          next_seq_nxt = next_seq_r + 1'b1;
        end
      end
      FUNC_ACK: begin
        if (mode_r == MODE_WAIT) begin
          armed_nxt = 1'b0;
          timer_nxt = '0;
          if (count_r != '0) begin
            pop   = 1'b1;
            send  = 1'b1;
            s_tag = rd_data_r[EW-1 -: TAG_W];
            s_seq = rd_data_r[SEQ_WIDTH-1:0];
          end else begin
            mode_nxt = MODE_IDLE;
          end
        end
      end
      FUNC_DONE: begin
        if (mode_r == MODE_SENDING) begin
          mode_nxt  = MODE_WAIT;
          timer_nxt = (timeout_r == '0) ? TIMER_W'(1) : timeout_r;
          armed_nxt = 1'b1;
        end
      end
      FUNC_TICK: begin
        if (armed_r && mode_r == MODE_WAIT) begin
          timer_nxt = timer_dec;
          if (timer_dec == '0) begin
            // Timeout: the last packet goes out again, link busy or not.
            armed_nxt = 1'b0;
            send      = 1'b1;
            resend    = 1'b1;
            s_tag     = last_tag_r;
            s_seq     = last_seq_r;
          end
        end else if (mode_r == MODE_IDLE && !in_data.link_busy && count_r != '0) begin
          pop   = 1'b1;
          send  = 1'b1;
          s_tag = rd_data_r[EW-1 -: TAG_W];
          s_seq = rd_data_r[SEQ_WIDTH-1:0];
        end
      end
      default: begin
      end
    endcase

    if (send) begin
      mode_nxt     = MODE_SENDING;
      last_tag_nxt = s_tag;
      last_seq_nxt = s_seq;
    end

    head_nxt  = pop  ? ptr_inc(head_r) : head_r;
    tail_nxt  = push ? ptr_inc(tail_r) : tail_r;
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end

    res.send_now     = send;
    res.send_tag     = s_tag;
    res.send_seq     = OSEQ_W'(s_seq);
    res.is_resend    = resend;
    res.sender_mode  = 2'(mode_nxt);
    res.queued_count = QCOUNT_W'(count_nxt);
    res.dropped      = drop;
  end

  assign wr_en   = accept && push;
  assign rd_addr = accept ? head_nxt : head_r;

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_IDLE;
      next_seq_r <= '0;
      head_r     <= '0;
      tail_r     <= '0;
      count_r    <= '0;
      last_tag_r <= '0;
      last_seq_r <= '0;
      timer_r    <= '0;
      armed_r    <= 1'b0;
    end else if (accept) begin
      mode_r     <= mode_nxt;
      next_seq_r <= next_seq_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      count_r    <= count_nxt;
      last_tag_r <= last_tag_nxt;
      last_seq_r <= last_seq_nxt;
      timer_r    <= timer_nxt;
      armed_r    <= armed_nxt;
    end
  end

  // Timeout register; the user must write it only while the sender is quiet (not enforced here).
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_r <= cfg_wdata;
    end
  end

  // Queue memory. A write that lands on the entry being read is forwarded so the head
  // register always reflects the memory after this cycle's write.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (tail_r == rd_addr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid    <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_hold) begin
      if (skid_valid_r) begin
        out_valid    <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_hold) begin
      out_data <= skid_valid_r ? skid_r : res;
    end
    if (out_hold && accept) begin
      skid_r <= res;
    end
  end

endmodule

`default_nettype wire

/* src/sawq_checker.sv */
`default_nettype none

module sawq_checker
  import sawq_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire out_t               out_data
);

  // A held result keeps its value until the transaction completes.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // Any send leaves the sender in the sending mode.
  a_send_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.send_now |-> out_data.sender_mode == 2'(MODE_SENDING))
    else $error("send without sending mode");

  // A retransmission is a send and never coincides with a drop.
  a_resend: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_resend |-> out_data.send_now && !out_data.dropped)
    else $error("resend flag without a send");

  // A dropped packet means a nonempty queue and no send in that transaction.
  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.dropped |-> !out_data.send_now && out_data.queued_count != '0)
    else $error("drop with send or empty queue");

endmodule

bind stop_and_wait_sender_queue_unit sawq_checker u_sawq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
